@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// bss_pkg
// Types and constants for the streaming substring search block.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 64;
   localparam int IndexWidth    = 17;
   localparam int LengthWidth   = 16;
   localparam int PatLenWidth   = 5;
   localparam int PatBytesMax   = 16;

   typedef logic [7:0] data_byte_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_HAYSTACK_LENGTH = 3'd0,
      CSR_PATTERN_LENGTH  = 3'd1,
      CSR_PATTERN_LOW     = 3'd2,
      CSR_PATTERN_HIGH    = 3'd3,
      CSR_START_OFFSET    = 3'd4
   } csr_index_type;

   // Index reported when the buffer holds no admissible match.
   localparam logic signed [IndexWidth-1:0] NoMatch = '1;

endpackage

`default_nettype wire

@@ rtl/buffer_substring_search.sv @@
// ----------------------------------------------------------------------------
// buffer_substring_search
// Streams a buffer one byte per transaction and reports the first position at
// which the configured pattern starts, at or after the effective start.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports                                 | transaction
//   req     | in        | req_valid, req_ready, req_data_byte   | one buffer byte
//   rsp     | out       | rsp_valid, rsp_ready, rsp_match_index,| one result per
//           |           | rsp_found                             | buffer
//   csr     | in        | csr_write_enable, csr_index,          | register write
//           |           | csr_write_data                        |
//
// One byte per cycle sustained unless a waiting result stalls a final byte. A
// byte is compared against the pattern while it sits in the input register, and
// the result register is loaded when that byte leaves the input register if it
// is the final byte of the buffer. Reset is synchronous and clears the window,
// position and handshake state. A result that waits in the result register
// stalls only the final byte of the next buffer; no byte is dropped.
`default_nettype none

module buffer_substring_search
   import bss_pkg::*;
#(
   parameter int PATTERN_MAX    = 16,
   parameter int POSITION_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [7:0]                   req_data_byte,

   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [IndexWidth-1:0]      rsp_match_index,
   output logic                              rsp_found,

   input  wire logic                         csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0]     csr_index,
   input  wire logic [CsrDataWidth-1:0]      csr_write_data
);

   `include "assert_macros.svh"

   localparam int HistDepth = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
   // Wide enough for positions, start offsets and their differences.
   localparam int FirstWidth = ((POSITION_WIDTH > 17) ? POSITION_WIDTH : 17) + 2;
   // A position of 32 bits or more behaves as a signed quantity in the comparison.
   localparam bit PosSigned = (POSITION_WIDTH >= 32);

   // Configuration registers.
   logic [LengthWidth-1:0]          haystack_length_ff;
   logic [PatLenWidth-1:0]          pattern_length_ff;
   logic [8*PatBytesMax-1:0]        pattern_ff;
   logic signed [IndexWidth-1:0]    start_offset_ff;

   // Input register.
   logic                            s1_valid_ff, s1_valid_in;
   data_byte_type                   s1_byte_ff, s1_byte_in;

   // Search state.
   data_byte_type                   hist_ff [HistDepth];
   data_byte_type                   hist_in [HistDepth];
   logic [POSITION_WIDTH-1:0]       pos_ff, pos_in;
   logic                            seen_ff, seen_in;
   logic [LengthWidth-1:0]          match_pos_ff, match_pos_in;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [IndexWidth-1:0]    rsp_index_ff, rsp_index_in;
   logic                            rsp_found_ff, rsp_found_in;

   logic                            s1_fire;
   logic                            emit;
   data_byte_type                   wnd [PATTERN_MAX];
   logic [PATTERN_MAX:1]            len_match;
   logic                            window_hit;
   logic signed [FirstWidth-1:0]    pos_ext;
   logic signed [FirstWidth-1:0]    first;
   logic signed [FirstWidth-1:0]    eff_start;
   logic [LengthWidth-1:0]          hlen_m1;
   logic [POSITION_WIDTH-1:0]       final_pos;
   logic                            final_byte;
   logic                            take_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         haystack_length_ff <= 16'd1;
         pattern_length_ff  <= '0;
         pattern_ff         <= '0;
         start_offset_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HAYSTACK_LENGTH: haystack_length_ff <= csr_write_data[LengthWidth-1:0];
            CSR_PATTERN_LENGTH:  pattern_length_ff  <= csr_write_data[PatLenWidth-1:0];
            CSR_PATTERN_LOW:     pattern_ff[63:0]   <= csr_write_data;
            CSR_PATTERN_HIGH:    pattern_ff[127:64] <= csr_write_data;
            CSR_START_OFFSET:    start_offset_ff    <= signed'(csr_write_data[IndexWidth-1:0]);
            default: ;
         endcase
      end
   end

   // The input register advances unless its byte closes a buffer while the
   // result register still holds a result that is not being taken.
   assign s1_fire   = s1_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_byte_in  = req_data_byte;
      end
   end

   // Window after the new byte is shifted in; entry 0 is the newest byte.
   always_comb begin
      wnd[0] = s1_byte_ff;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         wnd[k] = hist_ff[k-1];
      end
      for (int k = 0; k < HistDepth; k++) begin
         hist_in[k] = wnd[k];
      end
   end

   // One parallel compare per candidate length, then select by pattern_length.
   always_comb begin
      len_match  = '1;
      window_hit = 1'b0;
      for (int l = 1; l <= PATTERN_MAX; l++) begin
         for (int i = 0; i < l; i++) begin
            if (wnd[l-1-i] != pattern_ff[8*i +: 8]) begin
               len_match[l] = 1'b0;
            end
         end
      end
      for (int l = 1; l <= PATTERN_MAX; l++) begin
         if (pattern_length_ff == PatLenWidth'(l)) begin
            window_hit = len_match[l];
         end
      end
   end

   always_comb begin
      pos_ext = signed'({{(FirstWidth-POSITION_WIDTH){PosSigned & pos_ff[POSITION_WIDTH-1]}},
                         pos_ff});
      first   = pos_ext - signed'(FirstWidth'(pattern_length_ff)) + FirstWidth'(1);

      // A negative start counts back from the buffer end, clamped at zero.
      eff_start = FirstWidth'(start_offset_ff);
      if (start_offset_ff < 0) begin
         eff_start = eff_start + signed'(FirstWidth'(haystack_length_ff));
         if (eff_start < 0) begin
            eff_start = '0;
         end
      end

      hlen_m1    = haystack_length_ff - 16'd1;
      final_pos  = POSITION_WIDTH'({{POSITION_WIDTH{1'b0}}, hlen_m1});
      final_byte = (pos_ff == final_pos);

      take_match = !seen_ff && (pattern_length_ff != '0)
                   && (pattern_length_ff <= PatLenWidth'(PATTERN_MAX))
                   && (first >= 0) && (first >= eff_start) && window_hit;

      emit = (haystack_length_ff == '0) || final_byte;
   end

   always_comb begin
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      match_pos_in = match_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_found_in = rsp_found_ff;
      if (s1_fire) begin
         if (haystack_length_ff == '0) begin
            // An empty buffer ends at every byte.
            rsp_valid_in = 1'b1;
            rsp_index_in = NoMatch;
            rsp_found_in = 1'b0;
         end else begin
            if (take_match) begin
               seen_in      = 1'b1;
               match_pos_in = first[LengthWidth-1:0];
            end
            if (final_byte) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = seen_in;
               rsp_index_in = seen_in ? signed'({1'b0, match_pos_in}) : NoMatch;
            end else begin
               pos_in = pos_ff + POSITION_WIDTH'(1);
            end
         end
         if (emit) begin
            pos_in       = '0;
            seen_in      = 1'b0;
            match_pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         seen_ff      <= 1'b0;
         match_pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < HistDepth; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         match_pos_ff <= match_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            for (int k = 0; k < HistDepth; k++) begin
               hist_ff[k] <= hist_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff   <= s1_byte_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_found       = rsp_found_ff;

   `ASSERT_CLK(a_nomatch_code, clock, reset,
      rsp_valid_ff && !rsp_found_ff |-> rsp_index_ff == NoMatch,
      "result without a match must carry the no-match index")
   `ASSERT_CLK(a_found_positive, clock, reset,
      rsp_valid_ff && rsp_found_ff |-> !rsp_index_ff[IndexWidth-1],
      "result with a match must carry a non-negative index")
   `ASSERT_CLK(a_rearm_after_emit, clock, reset,
      s1_fire && emit |=> pos_ff == '0 && !seen_ff,
      "search state must rearm after the final byte of a buffer")
   `ASSERT_CLK(a_stage_holds, clock, reset,
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_byte_ff),
      "a byte waiting in the input register must not be overwritten")

endmodule

`default_nettype wire
